[hdl/mlcd_pkg.sv]
`timescale 1ns / 1ps

package mlcd_pkg;

    // command flag carried on the input tuser
    localparam logic CMD_ERASE = 1'b0;
    localparam logic CMD_PIXEL = 1'b1;

    // bytes sent to the panel
    localparam logic [7:0] OP_UPDATE  = 8'h01;
    localparam logic [7:0] OP_CLEAR   = 8'h04;
    localparam logic [7:0] DUMMY_BYTE = 8'h00;

    // most output beats caused by one input beat
    localparam int unsigned MAX_BEATS = 5;
    localparam int unsigned CNT_W     = 3;

    // one queued output beat
    typedef struct packed {
        logic [7:0] spi_byte;
        logic       end_of_transfer;
        logic       request_rejected;
    } mlcd_beat_t;

endpackage

[hdl/memory_lcd_line_update_framer_top.sv]
`timescale 1ns / 1ps
// latency: the beats caused by an accepted input appear on m_ in the next cycle
// throughput: one output beat per cycle while m_tready is high; an input beat makes
//   0 to 5 output beats, and a new input enters only when the 5-entry output queue
//   is empty or its final beat is leaving
// reset: aresetn low clears line counters, request flags and the output queue

module memory_lcd_line_update_framer_top
    import mlcd_pkg::*;
#(
    parameter int unsigned LINE_BYTES   = 16,
    parameter int unsigned SCREEN_LINES = 128
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // first_line[7:0], line_count[15:8], pixel_byte[23:16]
    input  logic [0:0]  s_tuser,   // command[0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // spi_byte[7:0]
    output logic [1:0]  m_tuser,   // end_of_transfer[0], request_rejected[1]
    output logic        m_tlast
);

    localparam int unsigned BIL_W = $clog2(LINE_BYTES + 1);

    typedef struct packed {
        logic [BIL_W-1:0] bil;
        logic [7:0]       li;
        logic             done;
    } adv_t;

    // step the byte and line counters, flag the end of the request
    function automatic adv_t advance(input logic [BIL_W-1:0] bil, input logic [7:0] li,
                                     input logic [7:0] cnt);
        adv_t         r;
        logic [BIL_W:0] b1;
        logic [8:0]   l1;
        b1     = {1'b0, bil} + {{BIL_W{1'b0}}, 1'b1};
        l1     = {1'b0, li} + 9'd1;
        r.bil  = b1[BIL_W-1:0];
        r.li   = li;
        r.done = 1'b0;
        if (b1 >= (BIL_W + 1)'(LINE_BYTES)) begin
            r.bil = '0;
            if (l1 >= {1'b0, cnt}) begin
                r.li   = '0;
                r.done = 1'b1;
            end else begin
                r.li = l1[7:0];
            end
        end
        return r;
    endfunction

    logic [BIL_W-1:0] bil_reg, bil_next;
    logic [7:0]       li_reg, li_next;
    logic             open_reg, open_next;
    logic             disc_reg, disc_next;
    mlcd_beat_t       q_reg [MAX_BEATS];
    mlcd_beat_t       q_next [MAX_BEATS];
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    mlcd_beat_t       res [MAX_BEATS];
    logic [CNT_W-1:0] res_n;

    logic       cmd;
    logic [7:0] first_line, line_count, pixel_byte;
    logic       in_acc, out_acc;

    assign cmd        = s_tuser[0];
    assign first_line = s_tdata[7:0];
    assign line_count = s_tdata[15:8];
    assign pixel_byte = s_tdata[23:16];

    // take a new beat when the queue is empty or its final beat is leaving
    assign m_tvalid = (cnt_reg != '0);
    assign out_acc  = m_tvalid && m_tready;
    assign s_tready = (cnt_reg == '0) || ((cnt_reg == CNT_W'(1)) && m_tready);
    assign in_acc   = s_tvalid && s_tready;

    assign m_tdata  = q_reg[0].spi_byte;
    assign m_tuser  = {q_reg[0].request_rejected, q_reg[0].end_of_transfer};
    assign m_tlast  = (cnt_reg == CNT_W'(1));

    // framing of one input beat
    always_comb begin
        logic             ok;
        logic             hdr;
        logic [BIL_W-1:0] bil_c;
        logic [7:0]       li_c;
        logic [8:0]       end_line;
        adv_t             a;
        logic [CNT_W-1:0] k;

        bil_next  = bil_reg;
        li_next   = li_reg;
        open_next = open_reg;
        disc_next = disc_reg;
        res_n     = '0;
        for (int i = 0; i < MAX_BEATS; i++) begin
            res[i] = '{spi_byte: DUMMY_BYTE, end_of_transfer: 1'b0, request_rejected: 1'b0};
        end
        end_line = {1'b0, first_line} + {1'b0, line_count};
        ok    = (first_line != 8'd0) && (line_count != 8'd0) &&
                (end_line <= 9'(SCREEN_LINES + 1));
        bil_c = open_reg ? bil_reg : '0;
        li_c  = open_reg ? li_reg : '0;
        hdr   = (bil_c == '0);
        a     = advance(bil_c, li_c, line_count);
        k     = '0;

        if (cmd == CMD_ERASE) begin
            // clear screen, ignored while a request is open or being discarded
            if (!(open_reg || disc_reg)) begin
                res[0] = '{spi_byte: OP_CLEAR, end_of_transfer: 1'b0, request_rejected: 1'b0};
                res[1] = '{spi_byte: DUMMY_BYTE, end_of_transfer: 1'b1,
                           request_rejected: 1'b0};
                res_n  = CNT_W'(2);
            end
        end else if (disc_reg) begin
            // drop the rest of a rejected request
            a        = advance(bil_reg, li_reg, line_count);
            bil_next = a.bil;
            li_next  = a.li;
            if (a.done) begin
                disc_next = 1'b0;
            end
        end else if (!open_reg && !ok) begin
            // range check failed on the first byte
            res[0] = '{spi_byte: 8'h00, end_of_transfer: 1'b0, request_rejected: 1'b1};
            res_n  = CNT_W'(1);
            a      = advance('0, 8'd0, line_count);
            if ((line_count != 8'd0) && !a.done) begin
                disc_next = 1'b1;
                bil_next  = a.bil;
                li_next   = a.li;
            end else begin
                bil_next = '0;
                li_next  = '0;
            end
        end else begin
            // line header, pixel byte, trailer at the end of the request
            if (hdr) begin
                res[0] = '{spi_byte: OP_UPDATE, end_of_transfer: 1'b0, request_rejected: 1'b0};
                res[1] = '{spi_byte: first_line + li_c, end_of_transfer: 1'b0,
                           request_rejected: 1'b0};
                k      = CNT_W'(2);
            end
            res[k] = '{spi_byte: pixel_byte, end_of_transfer: 1'b0, request_rejected: 1'b0};
            k      = k + CNT_W'(1);
            if (a.done) begin
                res[k]             = '{spi_byte: DUMMY_BYTE, end_of_transfer: 1'b0,
                                       request_rejected: 1'b0};
                res[k + CNT_W'(1)] = '{spi_byte: DUMMY_BYTE, end_of_transfer: 1'b1,
                                       request_rejected: 1'b0};
                k                  = k + CNT_W'(2);
            end
            res_n     = k;
            bil_next  = a.bil;
            li_next   = a.li;
            open_next = !a.done;
        end
    end

    // output queue: load on input beat, shift on output beat
    always_comb begin
        cnt_next = cnt_reg;
        for (int i = 0; i < MAX_BEATS; i++) begin
            q_next[i] = q_reg[i];
        end
        if (in_acc) begin
            cnt_next = res_n;
            for (int i = 0; i < MAX_BEATS; i++) begin
                q_next[i] = res[i];
            end
        end else if (out_acc) begin
            cnt_next = cnt_reg - CNT_W'(1);
            for (int i = 0; i < MAX_BEATS - 1; i++) begin
                q_next[i] = q_reg[i + 1];
            end
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bil_reg  <= '0;
            li_reg   <= '0;
            open_reg <= 1'b0;
            disc_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            if (in_acc) begin
                bil_reg  <= bil_next;
                li_reg   <= li_next;
                open_reg <= open_next;
                disc_reg <= disc_next;
            end
            cnt_reg <= cnt_next;
        end
    end

    // queue payload
    always_ff @(posedge aclk) begin
        for (int i = 0; i < MAX_BEATS; i++) begin
            q_reg[i] <= q_next[i];
        end
    end

endmodule

[hdl/mlcd_checker.sv]
`timescale 1ns / 1ps

module mlcd_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [23:0] s_tdata,
    input logic [0:0]  s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [7:0]  m_tdata,
    input logic [1:0]  m_tuser,
    input logic        m_tlast
);

    // a stalled output beat holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                                  && $stable(m_tlast))
        else $error("output beat changed while stalled");

    // a rejection is a single zero beat
    a_reject: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[1] |-> m_tlast && !m_tuser[0] && (m_tdata == 8'h00))
        else $error("malformed rejection beat");

    // chip select release ends the burst of an input beat
    a_eot_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tlast && (m_tdata == 8'h00))
        else $error("end of transfer not on a final dummy beat");

    // input only enters as the pending burst finishes
    a_in_gap: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && m_tvalid |-> m_tlast && m_tready)
        else $error("input accepted while output burst pending");

    // queue empty after reset
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid after reset");

endmodule

bind memory_lcd_line_update_framer_top mlcd_checker u_mlcd_checker (.*);

[tb/mlcd_spi_checker.sv]
`timescale 1ns / 1ps

module mlcd_spi_checker
    import mlcd_pkg::*;
#(
    parameter int unsigned LINE_BYTES   = 16,
    parameter int unsigned SCREEN_LINES = 128
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [23:0] s_tdata,   // first_line[7:0], line_count[15:8], pixel_byte[23:16]
    input  logic [0:0]  s_tuser,   // command[0]
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [7:0]  m_tdata,   // spi_byte[7:0]
    input  logic [1:0]  m_tuser,   // end_of_transfer[0], request_rejected[1]
    input  logic        m_tlast,
    output int unsigned fail_count,
    output int unsigned beats_pending,
    output int unsigned beats_checked,
    output int unsigned lines_written,
    output int unsigned requests_rejected,
    output int unsigned clears_sent
);

    typedef struct packed {
        mlcd_beat_t beat;
        logic       last;
    } spi_beat_t;

    // spi beats still owed by the framer, oldest first
    spi_beat_t spi_due_q[$];

    // shadow of the framer state
    int unsigned pix_in_line;
    int unsigned lines_done;
    logic        update_open;
    logic        dropping;

    initial begin
        fail_count        = 0;
        beats_pending     = 0;
        beats_checked     = 0;
        lines_written     = 0;
        requests_rejected = 0;
        clears_sent       = 0;
    end

    function automatic void owe_beat(input logic [7:0] b, input logic eot, input logic rej);
        spi_beat_t e;
        e.beat.spi_byte         = b;
        e.beat.end_of_transfer  = eot;
        e.beat.request_rejected = rej;
        e.last                  = 1'b0;
        spi_due_q.push_back(e);
    endfunction

    // byte and line bookkeeping; high when the request has run its lines
    function automatic logic step_line_counters(input logic [7:0] cnt);
        pix_in_line++;
        if (pix_in_line >= LINE_BYTES) begin
            pix_in_line = 0;
            lines_done++;
            if (lines_done >= cnt) begin
                lines_done = 0;
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    // spi beats caused by one input beat
    function automatic void predict_spi_beats(input logic cmd, input logic [7:0] first,
                                              input logic [7:0] cnt, input logic [7:0] pix);
        int unsigned base = spi_due_q.size();
        spi_beat_t   tail;
        logic        in_range;
        logic        done;
        if (cmd == CMD_ERASE) begin
            // clear is dropped while an update is open or being discarded
            if (!update_open && !dropping) begin
                owe_beat(OP_CLEAR, 1'b0, 1'b0);
                owe_beat(DUMMY_BYTE, 1'b1, 1'b0);
                clears_sent++;
            end
        end else if (dropping) begin
            if (step_line_counters(cnt))
                dropping = 1'b0;
        end else begin
            if (!update_open) begin
                in_range = (first >= 1) && (cnt >= 1) &&
                           (int'(first) + int'(cnt) <= int'(SCREEN_LINES) + 1);
                pix_in_line = 0;
                lines_done  = 0;
                if (!in_range) begin
                    // single reject beat, then the rest of the request is swallowed
                    owe_beat(8'h00, 1'b0, 1'b1);
                    requests_rejected++;
                    if (cnt >= 1 && !step_line_counters(cnt))
                        dropping = 1'b1;
                    if (!dropping) begin
                        pix_in_line = 0;
                        lines_done  = 0;
                    end
                end else begin
                    update_open = 1'b1;
                end
            end
            if (update_open) begin
                // line header: update command and 8-bit wrapped line address
                if (pix_in_line == 0) begin
                    owe_beat(OP_UPDATE, 1'b0, 1'b0);
                    owe_beat(8'(int'(first) + lines_done), 1'b0, 1'b0);
                    lines_written++;
                end
                owe_beat(pix, 1'b0, 1'b0);
                done = step_line_counters(cnt);
                if (done) begin
                    update_open = 1'b0;
                    owe_beat(DUMMY_BYTE, 1'b0, 1'b0);
                    owe_beat(DUMMY_BYTE, 1'b1, 1'b0);
                end
            end
        end
        // flag the final beat of this input
        if (spi_due_q.size() > base) begin
            tail      = spi_due_q.pop_back();
            tail.last = 1'b1;
            spi_due_q.push_back(tail);
        end
    endfunction

    function automatic void check_spi_beat();
        spi_beat_t e;
        if (spi_due_q.size() == 0) begin
            $display("%0t: unexpected spi beat byte %02h eot %0b rej %0b last %0b",
                     $time, m_tdata, m_tuser[0], m_tuser[1], m_tlast);
            fail_count++;
        end else begin
            e = spi_due_q.pop_front();
            beats_checked++;
            if (m_tdata !== e.beat.spi_byte || m_tuser[0] !== e.beat.end_of_transfer ||
                m_tuser[1] !== e.beat.request_rejected || m_tlast !== e.last) begin
                $display("%0t: spi beat mismatch, expected byte %02h eot %0b rej %0b last %0b",
                         $time, e.beat.spi_byte, e.beat.end_of_transfer,
                         e.beat.request_rejected, e.last);
                $display("%0t:                     actual byte %02h eot %0b rej %0b last %0b",
                         $time, m_tdata, m_tuser[0], m_tuser[1], m_tlast);
                fail_count++;
            end
        end
    endfunction

    // output beats are compared before the new input is predicted
    always @(posedge aclk) begin
        if (!aresetn) begin
            spi_due_q.delete();
            pix_in_line = 0;
            lines_done  = 0;
            update_open = 1'b0;
            dropping    = 1'b0;
        end else begin
            if (m_tvalid && m_tready)
                check_spi_beat();
            if (s_tvalid && s_tready)
                predict_spi_beats(s_tuser[0], s_tdata[7:0], s_tdata[15:8], s_tdata[23:16]);
        end
        beats_pending <= spi_due_q.size();
    end

endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
    import mlcd_pkg::*;

    localparam int unsigned LINE_BYTES   = 16;
    localparam int unsigned SCREEN_LINES = 128;
    localparam int unsigned HOLD_CYCLES  = 300;
    localparam int unsigned STALL_LIMIT  = 2000;

    logic        aclk     = 1'b0;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;   // first_line[7:0], line_count[15:8], pixel_byte[23:16]
    logic [0:0]  s_tuser;   // command[0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;   // spi_byte[7:0]
    logic [1:0]  m_tuser;   // end_of_transfer[0], request_rejected[1]
    logic        m_tlast;

    int unsigned fail_count;
    int unsigned beats_pending;
    int unsigned beats_checked;
    int unsigned lines_written;
    int unsigned requests_rejected;
    int unsigned clears_sent;

    int unsigned src_idle_pct  = 0;
    int unsigned sink_stall_pct = 0;
    int unsigned live_items    = 0;
    int unsigned quiet_cycles  = 0;
    int unsigned hold_left     = 0;
    logic        hold_go       = 1'b0;
    logic        hold_used     = 1'b0;

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    memory_lcd_line_update_framer_top #(
        .LINE_BYTES  (LINE_BYTES),
        .SCREEN_LINES(SCREEN_LINES)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser),
        .m_tlast (m_tlast)
    );

    mlcd_spi_checker #(
        .LINE_BYTES  (LINE_BYTES),
        .SCREEN_LINES(SCREEN_LINES)
    ) spi_chk (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_tvalid         (s_tvalid),
        .s_tready         (s_tready),
        .s_tdata          (s_tdata),
        .s_tuser          (s_tuser),
        .m_tvalid         (m_tvalid),
        .m_tready         (m_tready),
        .m_tdata          (m_tdata),
        .m_tuser          (m_tuser),
        .m_tlast          (m_tlast),
        .fail_count       (fail_count),
        .beats_pending    (beats_pending),
        .beats_checked    (beats_checked),
        .lines_written    (lines_written),
        .requests_rejected(requests_rejected),
        .clears_sent      (clears_sent)
    );

    // receiver: random stalls, plus one long hold-off on request
    always @(posedge aclk) begin
        if (hold_go && !hold_used) begin
            hold_used <= 1'b1;
            hold_left <= HOLD_CYCLES;
            m_tready  <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    // watchdog on cycles with no beat moving on either side
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("%0t: no beat moved for %0d cycles", $time, quiet_cycles);
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    // one input beat, with random idle cycles ahead of it
    task automatic send_beat(input logic cmd, input logic [7:0] first,
                             input logic [7:0] cnt, input logic [7:0] pix);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {pix, cnt, first};
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        live_items++;
    endtask

    task automatic send_clear();
        send_beat(CMD_ERASE, 8'($urandom_range(255)), 8'($urandom_range(255)),
                  8'($urandom_range(255)));
    endtask

    // good update; the first beat may carry a larger count tag than the real one
    task automatic send_update(input int unsigned first, input int unsigned cnt,
                               input int unsigned tag_cnt, input logic noisy);
        int unsigned i;
        int unsigned line_tag;
        for (i = 0; i < cnt * LINE_BYTES; i++) begin
            line_tag = first;
            // later beats may carry another first line, which moves the address
            if (noisy && i != 0 && $urandom_range(9) == 0)
                line_tag = $urandom_range(255);
            if (noisy && $urandom_range(19) == 0)
                send_beat(CMD_ERASE, 8'($urandom_range(255)), 8'($urandom_range(255)), 8'h00);
            send_beat(CMD_PIXEL, 8'(line_tag), 8'(i == 0 ? tag_cnt : cnt),
                      8'($urandom_range(255)));
        end
    endtask

    // out-of-range request, one line of beats; the tail carries a count of one
    task automatic send_reject();
        int unsigned first;
        int unsigned cnt;
        int unsigned i;
        case ($urandom_range(2))
            0: begin
                first = 0;
                cnt   = $urandom_range(1, 255);
            end
            1: begin
                first = $urandom_range(SCREEN_LINES + 1, 255);
                cnt   = $urandom_range(1, 255);
            end
            default: begin
                first = $urandom_range(1, SCREEN_LINES);
                cnt   = $urandom_range(SCREEN_LINES + 2 - first, 255);
            end
        endcase
        send_beat(CMD_PIXEL, 8'(first), 8'(cnt), 8'($urandom_range(255)));
        for (i = 1; i < LINE_BYTES; i++) begin
            if ($urandom_range(9) == 0)
                send_beat(CMD_ERASE, 8'($urandom_range(255)), 8'($urandom_range(255)), 8'h00);
            send_beat(CMD_PIXEL, 8'($urandom_range(255)), 8'd1, 8'($urandom_range(255)));
        end
    endtask

    // fully random beat; a pixel beat is followed by zero-count beats to close the line
    task automatic send_noise();
        logic        cmd;
        int unsigned i;
        cmd = 1'($urandom_range(1));
        send_beat(cmd, 8'($urandom_range(255)), 8'($urandom_range(255)),
                  8'($urandom_range(255)));
        if (cmd == CMD_PIXEL) begin
            for (i = 1; i < LINE_BYTES; i++) begin
                send_beat(CMD_PIXEL, 8'($urandom_range(255)), 8'd0, 8'($urandom_range(255)));
            end
        end
    endtask

    task automatic send_random_request();
        int unsigned pick;
        int unsigned first;
        int unsigned span;
        int unsigned cnt;
        int unsigned tag_cnt;
        pick = $urandom_range(99);
        if (pick < 55) begin
            first   = $urandom_range(1, SCREEN_LINES);
            span    = SCREEN_LINES + 1 - first;
            cnt     = (span >= 2 && $urandom_range(3) == 0) ? 2 : 1;
            tag_cnt = ($urandom_range(3) == 0) ? $urandom_range(cnt, span) : cnt;
            send_update(first, cnt, tag_cnt, 1'($urandom_range(1)));
        end else if (pick < 70) begin
            send_reject();
        end else if (pick < 80) begin
            // empty request
            send_beat(CMD_PIXEL, 8'($urandom_range(255)), 8'd0, 8'($urandom_range(255)));
        end else if (pick < 92) begin
            send_clear();
        end else begin
            send_noise();
        end
    endtask

    // stop offering and let every owed beat come out
    task automatic wait_drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (beats_pending != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    initial begin
        int unsigned phase;
        int unsigned goal;
        int unsigned i;
        int unsigned src_pct[4];
        int unsigned sink_pct[4];
        src_pct  = '{0, 60, 0, 23};
        sink_pct = '{0, 0, 60, 23};
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= CMD_ERASE;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: clear, write of the last screen line with a clear inside it,
        // empty requests at the tag extremes, clear again
        send_clear();
        for (i = 0; i < LINE_BYTES; i++) begin
            if (i == LINE_BYTES / 2)
                send_beat(CMD_ERASE, 8'hFF, 8'hFF, 8'hFF);
            send_beat(CMD_PIXEL, 8'(SCREEN_LINES), 8'd1, i[0] ? 8'h00 : 8'hFF);
        end
        send_beat(CMD_PIXEL, 8'd10, 8'd0, 8'h5A);
        send_beat(CMD_PIXEL, 8'd0, 8'd0, 8'h00);
        send_beat(CMD_PIXEL, 8'hFF, 8'd0, 8'hFF);
        send_clear();
        wait_drain();

        // long receiver hold-off while input keeps coming, then a full drain
        hold_go <= 1'b1;
        send_update(1, 1, SCREEN_LINES, 1'b0);
        send_update(SCREEN_LINES - 1, 2, 2, 1'b0);
        send_clear();
        wait_drain();

        goal = live_items;
        for (phase = 0; phase < 4; phase++) begin
            src_idle_pct   = src_pct[phase];
            sink_stall_pct = sink_pct[phase];
            goal += 32;
            while (live_items < goal)
                send_random_request();
            wait_drain();
        end

        $display("run covered %0d input beats over four stall mixes and a long hold-off",
                 live_items);
        $display("checked %0d spi beats: %0d line writes, %0d rejected requests, %0d clears",
                 beats_checked, lines_written, requests_rejected, clears_sent);
        if (fail_count == 0 && beats_pending == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
